FILE: rtl/pbd_pkg.sv
// Package for the batch deframer: result kind codes, reset values of the
// configuration registers and the command passed from front to back.
// No dependencies.
`default_nettype none
package pbd_pkg;

	localparam logic [31:0] SYNC_RESET   = 32'h7cd215d8;
	localparam logic [31:0] IDLE_RESET   = 32'h7a89c197;
	localparam int          CW_PER_BATCH = 16;
	localparam int          QDEPTH       = 4;
	localparam int          QPTR_W       = $clog2(QDEPTH);

	localparam logic [1:0] KIND_ADDR  = 2'd0;
	localparam logic [1:0] KIND_ALPHA = 2'd1;
	localparam logic [1:0] KIND_DIGIT = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [0:0] REG_SYNC = 1'd0;
	localparam logic [0:0] REG_IDLE = 1'd1;

	localparam logic [2:0] FUNC_NONE = 3'd4;

	typedef struct packed {
		logic        tmo;
		logic [31:0] cw;
		logic [3:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage
`default_nettype wire

FILE: rtl/pbd_ifs.sv
// Channel interfaces of the batch deframer: input items, results and
// configuration writes. Depends on nothing.
`default_nettype none
interface pbd_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;
	modport source (output valid, action, rx_byte, input ready);
	modport sink (input valid, action, rx_byte, output ready);
endinterface

interface pbd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [20:0] ric;
	logic [1:0]  func_code;
	logic        func_valid;
	logic [6:0]  symbol;
	logic        last;
	modport source (output valid, kind, ric, func_code, func_valid, symbol, last,
		input ready);
	modport sink (input valid, kind, ric, func_code, func_valid, symbol, last,
		output ready);
endinterface

interface pbd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pocsag_batch_deframer_unit.sv
// Top level of the batch deframer: configuration registers, front, command
// queue and back. Depends on pbd_pkg, pbd_ifs, pbd_front, pbd_queue, pbd_back.
//
// Use:
//   item   - input beats: action 0 carries a received byte (MSB first in time),
//            action 1 is a receive timeout tick.
//   result - output beats: address, character, digit nibble or message end,
//            with last set on the final beat caused by one input beat.
//   cfg    - register writes, index 0 sync word, index 1 idle word; always ready.
// The front takes one input beat per cycle while the four-entry command queue
// has room; a byte completing a codeword or a timeout pushes one command.
// The back takes a command while idle, then emits its result beats in turn
// for an address or a message end, or steps through the message bits of a
// message codeword, with an extra step when a character and a digit finish
// on the same bit. An address or message end passes through the command
// queue, the back's state register and the result register before it
// appears. Sustained batch throughput is set by the back's bit sequencer.
// Reset clears all hunt, batch and message state and loads the default sync
// and idle words. While the receiver stalls, the result register holds, the
// back waits, and the front keeps taking beats until the queue fills.
`default_nettype none
module pocsag_batch_deframer_unit import pbd_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	pbd_item_if.sink     item,
	pbd_result_if.source result,
	pbd_cfg_if.sink      cfg
);

	logic [31:0] sync_q;
	logic [31:0] idle_q;
	qctl_t       front_ctl;
	qctl_t       queue_ctl;
	cmd_t        push_cmd;
	cmd_t        head;
	logic        q_empty;
	logic        pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
			idle_q <= IDLE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SYNC: sync_q <= cfg.data;
				REG_IDLE: idle_q <= cfg.data;
				default:  sync_q <= sync_q;
			endcase
		end
	end

	pbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sync_word (sync_q),
		.item      (item),
		.q_full    (queue_ctl.full),
		.qctl      (front_ctl),
		.push_cmd  (push_cmd)
	);

	pbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (front_ctl),
		.ctl_out  (queue_ctl),
		.push_cmd (push_cmd),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	pbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.idle_word (idle_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire

FILE: rtl/pbd_queue.sv
// Short command queue between the front and the back of the deframer.
// Depends on pbd_pkg.
`default_nettype none
module pbd_queue import pbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  qctl_t ctl_in,
	output qctl_t ctl_out,
	input  cmd_t  push_cmd,
	input  logic  pop,
	output logic  empty,
	output cmd_t  head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty        = (cnt_q == '0);
	assign ctl_out.full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign ctl_out.push = ctl_in.push;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (ctl_in.push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl_in.push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({ctl_in.push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pbd_front.sv
// Front of the deframer: sync hunt over the bit stream and codeword assembly.
// Pushes one command per finished codeword or timeout. Depends on pbd_pkg.
`default_nettype none
module pbd_front import pbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] sync_word,
	pbd_item_if.sink    item,
	input  logic        q_full,
	output qctl_t       qctl,
	output cmd_t        push_cmd
);

	logic [31:0] sync_shift_q;
	logic        in_batch_q;
	logic [7:0]  carry_q;
	logic [2:0]  offset_q;
	logic [3:0]  idx_q;
	logic [23:0] asm_q;
	logic [1:0]  nbytes_q;

	logic        acc;
	logic [39:0] window;
	logic        hit;
	logic [2:0]  hit_b;
	logic [7:0]  slot;
	logic        cw_done;
	logic        batch_end;

	assign item.ready = !q_full;
	assign acc        = item.valid && item.ready;
	assign window     = {sync_shift_q, item.rx_byte};
	assign slot       = 8'({carry_q, item.rx_byte} >> offset_q);
	assign cw_done    = in_batch_q && (nbytes_q == 2'd3);
	assign batch_end  = (idx_q >= 4'(CW_PER_BATCH - 1));

	always_comb begin
		hit   = 1'b0;
		hit_b = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (window[(7-b) +: 32] == sync_word) begin
				hit   = 1'b1;
				hit_b = 3'(b);
			end
		end
	end

	assign qctl.push     = acc && (item.action || cw_done);
	assign qctl.full     = q_full;
	assign push_cmd.tmo  = item.action;
	assign push_cmd.cw   = {asm_q, slot};
	assign push_cmd.idx  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_shift_q <= '0;
			in_batch_q   <= 1'b0;
			carry_q      <= '0;
			offset_q     <= '0;
			idx_q        <= '0;
			asm_q        <= '0;
			nbytes_q     <= '0;
		end else if (acc) begin
			if (item.action) begin
				in_batch_q <= 1'b0;
			end else if (in_batch_q) begin
				carry_q  <= item.rx_byte;
				asm_q    <= {asm_q[15:0], slot};
				nbytes_q <= nbytes_q + 1'b1;
				if (cw_done) begin
					if (batch_end) begin
						in_batch_q <= 1'b0;
						idx_q      <= '0;
						if (offset_q != 3'd0) begin
							sync_shift_q <= {sync_shift_q[23:0], item.rx_byte};
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end else if (hit) begin
				sync_shift_q <= window[(7 - hit_b) +: 32];
				in_batch_q   <= 1'b1;
				offset_q     <= 3'd7 - hit_b;
				carry_q      <= item.rx_byte;
				idx_q        <= '0;
				nbytes_q     <= '0;
				asm_q        <= '0;
			end else begin
				sync_shift_q <= window[31:0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pbd_back.sv
// Back of the deframer: message state, address decoding and character and
// digit unpacking, one result beat per cycle unless the receiver stalls. Depends on pbd_pkg.
`default_nettype none
module pbd_back import pbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] idle_word,
	input  logic        q_empty,
	input  cmd_t        head,
	output logic        pop,
	pbd_result_if.source result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_END  = 3'd1;
	localparam logic [2:0] S_ADDR = 3'd2;
	localparam logic [2:0] S_TEND = 3'd3;
	localparam logic [2:0] S_BITS = 3'd4;

	logic [2:0]  state_q;
	logic [31:0] cw_q;
	logic [4:0]  bit_q;
	logic        split_q;
	logic [3:0]  rem_q;
	logic        running_q;
	logic [20:0] ric_q;
	logic [2:0]  func_q;
	logic [20:0] hd_ric_q;
	logic [2:0]  hd_func_q;
	logic [7:0]  cacc_q;
	logic [2:0]  ccnt_q;
	logic [7:0]  dacc_q;
	logic [2:0]  dcnt_q;

	logic        ov_q;
	logic [1:0]  kind_q;
	logic [20:0] ric_out_q;
	logic [1:0]  fcode_q;
	logic        fvalid_q;
	logic [6:0]  sym_q;
	logic        last_q;

	logic        can_emit;
	logic        hd_idle;
	logic        hd_addr;
	logic        cur_bit;
	logic [7:0]  ca_n;
	logic [2:0]  cc_n;
	logic [7:0]  da_n;
	logic [2:0]  dc_n;
	logic        cfire;
	logic        dfire;
	logic        emit;
	logic [1:0]  e_kind;
	logic [20:0] e_ric;
	logic [2:0]  e_func;
	logic [6:0]  e_sym;
	logic        advance;

	assign can_emit = !ov_q || result.ready;
	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign hd_idle  = (head.cw == idle_word);
	assign hd_addr  = !head.cw[31];
	assign cur_bit  = cw_q[bit_q];
	assign ca_n     = {cur_bit, cacc_q[7:1]};
	assign cc_n     = ccnt_q + 1'b1;
	assign da_n     = {cur_bit, dacc_q[7:1]};
	assign dc_n     = dcnt_q + 1'b1;
	assign cfire    = (cc_n == 3'd7);
	assign dfire    = (dc_n == 3'd4);
	assign advance  = split_q || !(cfire && dfire);

	always_comb begin
		emit   = 1'b0;
		e_kind = KIND_END;
		e_ric  = ric_q;
		e_func = func_q;
		e_sym  = '0;
		case (state_q)
			S_END, S_TEND: begin
				emit = can_emit;
			end
			S_ADDR: begin
				emit   = can_emit;
				e_kind = KIND_ADDR;
				e_ric  = hd_ric_q;
				e_func = hd_func_q;
			end
			S_BITS: begin
				if (split_q) begin
					emit   = can_emit;
					e_kind = KIND_DIGIT;
					e_sym  = {3'd0, dacc_q[7:4]};
				end else if (cfire) begin
					emit   = can_emit;
					e_kind = KIND_ALPHA;
					e_sym  = ca_n[7:1];
				end else if (dfire) begin
					emit   = can_emit;
					e_kind = KIND_DIGIT;
					e_sym  = {3'd0, da_n[7:4]};
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign result.valid      = ov_q;
	assign result.kind       = kind_q;
	assign result.ric        = ric_out_q;
	assign result.func_code  = fcode_q;
	assign result.func_valid = fvalid_q;
	assign result.symbol     = sym_q;
	assign result.last       = last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q    <= e_kind;
			ric_out_q <= e_ric;
			fvalid_q  <= !e_func[2];
			fcode_q   <= e_func[2] ? 2'd0 : e_func[1:0];
			sym_q     <= e_sym;
			last_q    <= (rem_q == 4'd1);
		end
		if (pop) begin
			cw_q      <= head.cw;
			hd_ric_q  <= {head.cw[30:13], head.idx[3:1]};
			hd_func_q <= {1'b0, head.cw[12:11]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ov_q      <= 1'b0;
			bit_q     <= '0;
			split_q   <= 1'b0;
			rem_q     <= '0;
			running_q <= 1'b0;
			ric_q     <= '0;
			func_q    <= FUNC_NONE;
			cacc_q    <= '0;
			ccnt_q    <= '0;
			dacc_q    <= '0;
			dcnt_q    <= '0;
		end else begin
			if (emit) begin
				ov_q  <= 1'b1;
				rem_q <= rem_q - 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.tmo) begin
							rem_q <= 4'd1;
							if (running_q) begin
								state_q <= S_TEND;
							end
						end else if (hd_addr && !hd_idle) begin
							rem_q   <= running_q ? 4'd2 : 4'd1;
							state_q <= running_q ? S_END : S_ADDR;
						end else if (hd_addr) begin
							cacc_q <= '0;
							ccnt_q <= '0;
							dacc_q <= '0;
							dcnt_q <= '0;
						end else begin
							if (!hd_idle) begin
								running_q <= 1'b1;
							end
							bit_q   <= 5'd30;
							split_q <= 1'b0;
							rem_q   <= (ccnt_q != 3'd0) ? 4'd8 : 4'd7;
							state_q <= S_BITS;
						end
					end
				end
				S_END: begin
					if (can_emit) begin
						running_q <= 1'b0;
						state_q   <= S_ADDR;
					end
				end
				S_ADDR: begin
					if (can_emit) begin
						ric_q     <= hd_ric_q;
						func_q    <= hd_func_q;
						running_q <= 1'b1;
						cacc_q    <= '0;
						ccnt_q    <= '0;
						dacc_q    <= '0;
						dcnt_q    <= '0;
						state_q   <= S_IDLE;
					end
				end
				S_TEND: begin
					if (can_emit) begin
						running_q <= 1'b0;
						ric_q     <= '0;
						func_q    <= FUNC_NONE;
						state_q   <= S_IDLE;
					end
				end
				S_BITS: begin
					if (can_emit) begin
						if (split_q) begin
							dacc_q  <= '0;
							dcnt_q  <= '0;
							split_q <= 1'b0;
						end else begin
							cacc_q <= cfire ? 8'd0 : ca_n;
							ccnt_q <= cfire ? 3'd0 : cc_n;
							if (dfire && !cfire) begin
								dacc_q <= '0;
								dcnt_q <= '0;
							end else begin
								dacc_q <= da_n;
								dcnt_q <= dc_n;
							end
							if (cfire && dfire) begin
								split_q <= 1'b1;
							end
						end
						if (advance) begin
							if (bit_q == 5'd11) begin
								state_q <= S_IDLE;
							end else begin
								bit_q <= bit_q - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
